FILE: design/mss_pkg.sv
// Package for the multichannel sample scheduler: register indexes, reset values,
// rate classes, the sequencer state type and the channel-to-class map.
// No dependencies.
package mss_pkg;

    localparam int unsigned STAMP_W   = 32;
    localparam int unsigned PERIOD_W  = 16;
    localparam int unsigned CHAN_W    = 5;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned DIV_CNT_W = 5;
    localparam int unsigned M_TDATA_W = 40;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_BATTERY    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_ATMOSPHERE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_IMU        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_GPS        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_VOC        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FILE_PERIOD       = 3'd5;

    // Reset values
    localparam logic [PERIOD_W-1:0] RST_PERIOD_BATTERY    = 16'd500;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_ATMOSPHERE = 16'd500;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_IMU        = 16'd100;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_GPS        = 16'd1000;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_VOC        = 16'd500;
    localparam logic [STAMP_W-1:0]  RST_FILE_PERIOD       = 32'd60000;

    // Result kinds (carried on tuser)
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FILE   = 1'b1;

    typedef enum logic [2:0] {
        CLS_BATTERY    = 3'd0,
        CLS_ATMOSPHERE = 3'd1,
        CLS_IMU        = 3'd2,
        CLS_GPS        = 3'd3,
        CLS_VOC        = 3'd4
    } cls_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_DIV  = 6'b000100,
        S_BASE = 6'b001000,
        S_CMP  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    // Fixed channel map; channels past the map fall into the VOC class
    function automatic cls_t class_of(input logic [CHAN_W-1:0] ch);
        cls_t cls;
        priority if (ch == 5'd0)  cls = CLS_BATTERY;
        else if (ch <= 5'd5)      cls = CLS_ATMOSPHERE;
        else if (ch <= 5'd14)     cls = CLS_IMU;
        else if (ch <= 5'd19)     cls = CLS_GPS;
        else                      cls = CLS_VOC;
        return cls;
    endfunction

endpackage

FILE: design/multichannel_sample_scheduler_core.sv
// Multichannel periodic sample scheduler, top level and only module.
// Depends on mss_pkg (scoped references only).
//
// Usage
// - Slave channel: one item per millisecond tick, s_tdata = now_ms (32 bits).
//   s_tready is high only while the sequencer is idle.
// - Master channel: zero or more result items per tick, in order: an optional
//   new-file request (tuser = 1, channel 0), then one sample request
//   (tuser = 0) for each due channel in ascending index; tlast marks the
//   final item of the tick. A tick with nothing due gives no item.
// - Config port: cfg_wr_en / cfg_addr / cfg_wdata write one register per
//   cycle; indexes 0..4 are class periods (low 16 bits), 5 is the file
//   period. Indexes 6 and 7 are dropped. Write only while idle.
// Timing
// - One shared restoring divider works out stored % period, one bit a cycle.
//   Each of the NUM_CHANNELS+1 checks runs load, 32 divide steps, base and
//   compare in turn; the emit scan then walks the entries in order and
//   waits whenever the result register is stalled.
// - The result register holds its item while m_tready is low; the emit scan
//   waits on it, and the slave side stays closed until the scan is done.
// Reset: aresetn (synchronous, active low) restores the reset periods,
// clears all stored times, the due mask and the output valid.
module multichannel_sample_scheduler_core #(
    parameter int unsigned NUM_CHANNELS = 22
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // slave: [31:0] now_ms
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mss_pkg::STAMP_W-1:0]         s_tdata,
    // master: [4:0] channel, [36:5] stamp, [39:37] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mss_pkg::M_TDATA_W-1:0]       m_tdata,
    // master: [0] kind
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [mss_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mss_pkg::STAMP_W-1:0]         cfg_wdata
);

    // Entry 0 is the file check, entry k+1 is channel k
    localparam int unsigned NUM_ENTRIES = NUM_CHANNELS + 1;
    localparam int unsigned IDX_W = $clog2(NUM_ENTRIES);
    localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int unsigned SW    = mss_pkg::STAMP_W;

    mss_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    eidx_reg, eidx_next;
    logic [mss_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SW-1:0]       now_reg, now_next;
    logic [SW-1:0]       op_stored_reg, op_stored_next;
    logic [SW-1:0]       op_period_reg, op_period_next;
    logic [SW-1:0]       dvd_reg, dvd_next;
    logic [SW-1:0]       rem_reg, rem_next;
    logic [SW-1:0]       base_reg, base_next;
    logic [NUM_ENTRIES-1:0] mask_reg, mask_next;

    logic [mss_pkg::PERIOD_W-1:0] per_bat_reg, per_atm_reg, per_imu_reg;
    logic [mss_pkg::PERIOD_W-1:0] per_gps_reg, per_voc_reg;
    logic [SW-1:0]       file_period_reg;
    logic [SW-1:0]       last_file_reg;
    logic [SW-1:0]       last_time_reg [NUM_CHANNELS];

    logic                    m_valid_reg, m_valid_next;
    logic [mss_pkg::CHAN_W-1:0] m_chan_reg, m_chan_next;
    logic [SW-1:0]           m_stamp_reg, m_stamp_next;
    logic                    m_kind_reg, m_kind_next;
    logic                    m_last_reg, m_last_next;

    // Operand selection for the entry under test
    logic [IDX_W-1:0]    sel_ch;
    mss_pkg::cls_t       sel_cls;
    logic [SW-1:0]       cls_period;
    logic [SW-1:0]       sel_period;
    logic [SW-1:0]       sel_stored;

    // Divider step
    logic [SW:0]         div_shift;
    logic                div_ge;

    logic                due;
    logic                slot_free;
    logic [NUM_ENTRIES-1:0] mask_clr;
    logic [IDX_W-1:0]    emit_ch;

    assign sel_ch  = idx_reg - IDX_W'(1);
    assign sel_cls = mss_pkg::class_of(mss_pkg::CHAN_W'(sel_ch));

    always_comb begin
        unique case (sel_cls)
            mss_pkg::CLS_BATTERY:    cls_period = SW'(per_bat_reg);
            mss_pkg::CLS_ATMOSPHERE: cls_period = SW'(per_atm_reg);
            mss_pkg::CLS_IMU:        cls_period = SW'(per_imu_reg);
            mss_pkg::CLS_GPS:        cls_period = SW'(per_gps_reg);
            mss_pkg::CLS_VOC:        cls_period = SW'(per_voc_reg);
            default:                 cls_period = SW'(per_voc_reg);
        endcase
    end

    assign sel_period = (idx_reg == '0) ? file_period_reg : cls_period;
    assign sel_stored = (idx_reg == '0) ? last_file_reg
                                        : last_time_reg[sel_ch[CH_W-1:0]];

    assign div_shift = {rem_reg, dvd_reg[SW-1]};
    assign div_ge    = div_shift >= {1'b0, op_period_reg};

    // Due when the time since the rounded-down base exceeds the period
    assign due = (now_reg - base_reg) > op_period_reg;

    assign slot_free = !m_valid_reg || m_tready;

    always_comb begin
        mask_clr = mask_reg;
        mask_clr[eidx_reg] = 1'b0;
    end

    assign emit_ch = eidx_reg - IDX_W'(1);

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        eidx_next      = eidx_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        op_stored_next = op_stored_reg;
        op_period_next = op_period_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        base_next      = base_reg;
        mask_next      = mask_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_chan_next    = m_chan_reg;
        m_stamp_next   = m_stamp_reg;
        m_kind_next    = m_kind_reg;
        m_last_next    = m_last_reg;

        unique case (state_reg)
            mss_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    now_next   = s_tdata;
                    idx_next   = '0;
                    mask_next  = '0;
                    state_next = mss_pkg::S_LOAD;
                end
            end
            mss_pkg::S_LOAD: begin
                // Latch operands and start the divider on the stored time
                op_stored_next = sel_stored;
                op_period_next = sel_period;
                dvd_next       = sel_stored;
                rem_next       = '0;
                cnt_next       = '0;
                state_next     = mss_pkg::S_DIV;
            end
            mss_pkg::S_DIV: begin
                // One restoring step: shift in a dividend bit, subtract if it fits
                rem_next = div_ge ? SW'(div_shift - {1'b0, op_period_reg})
                                  : div_shift[SW-1:0];
                dvd_next = {dvd_reg[SW-2:0], 1'b0};
                cnt_next = cnt_reg + mss_pkg::DIV_CNT_W'(1);
                if (cnt_reg == '1) begin
                    state_next = mss_pkg::S_BASE;
                end
            end
            mss_pkg::S_BASE: begin
                // A zero period applies no rounding
                base_next  = (op_period_reg == '0) ? op_stored_reg
                                                   : op_stored_reg - rem_reg;
                state_next = mss_pkg::S_CMP;
            end
            mss_pkg::S_CMP: begin
                if (due) begin
                    mask_next[idx_reg] = 1'b1;
                end
                if (idx_reg == IDX_W'(NUM_CHANNELS)) begin
                    eidx_next  = '0;
                    state_next = mss_pkg::S_EMIT;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = mss_pkg::S_LOAD;
                end
            end
            mss_pkg::S_EMIT: begin
                priority if (mask_reg == '0) begin
                    state_next = mss_pkg::S_IDLE;
                end else if (mask_reg[eidx_reg]) begin
                    // Hold until the result register can take the item
                    if (slot_free) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = (eidx_reg == '0) ? mss_pkg::KIND_FILE
                                                        : mss_pkg::KIND_SAMPLE;
                        m_chan_next  = (eidx_reg == '0) ? '0
                                                        : mss_pkg::CHAN_W'(emit_ch);
                        m_stamp_next = now_reg;
                        m_last_next  = (mask_clr == '0);
                        mask_next    = mask_clr;
                        eidx_next    = eidx_reg + IDX_W'(1);
                    end
                end else begin
                    eidx_next = eidx_reg + IDX_W'(1);
                end
            end
            default: begin
                state_next = mss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mss_pkg::S_IDLE;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        eidx_reg      <= eidx_next;
        cnt_reg       <= cnt_next;
        now_reg       <= now_next;
        op_stored_reg <= op_stored_next;
        op_period_reg <= op_period_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        base_reg      <= base_next;
        m_chan_reg    <= m_chan_next;
        m_stamp_reg   <= m_stamp_next;
        m_kind_reg    <= m_kind_next;
        m_last_reg    <= m_last_next;
    end

    // Configuration registers; out-of-range indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            per_bat_reg     <= mss_pkg::RST_PERIOD_BATTERY;
            per_atm_reg     <= mss_pkg::RST_PERIOD_ATMOSPHERE;
            per_imu_reg     <= mss_pkg::RST_PERIOD_IMU;
            per_gps_reg     <= mss_pkg::RST_PERIOD_GPS;
            per_voc_reg     <= mss_pkg::RST_PERIOD_VOC;
            file_period_reg <= mss_pkg::RST_FILE_PERIOD;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mss_pkg::REG_PERIOD_BATTERY:    per_bat_reg <= cfg_wdata[15:0];
                mss_pkg::REG_PERIOD_ATMOSPHERE: per_atm_reg <= cfg_wdata[15:0];
                mss_pkg::REG_PERIOD_IMU:        per_imu_reg <= cfg_wdata[15:0];
                mss_pkg::REG_PERIOD_GPS:        per_gps_reg <= cfg_wdata[15:0];
                mss_pkg::REG_PERIOD_VOC:        per_voc_reg <= cfg_wdata[15:0];
                mss_pkg::REG_FILE_PERIOD:       file_period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stored times: advance to the tick time when the entry is found due
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_file_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                last_time_reg[i] <= '0;
            end
        end else if (state_reg == mss_pkg::S_CMP && due) begin
            if (idx_reg == '0) begin
                last_file_reg <= now_reg;
            end else begin
                last_time_reg[sel_ch[CH_W-1:0]] <= now_reg;
            end
        end
    end

    assign s_tready = (state_reg == mss_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(mss_pkg::M_TDATA_W - SW - mss_pkg::CHAN_W){1'b0}},
                       m_stamp_reg, m_chan_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // No due entries may be left over once the sequencer is back to idle
    a_idle_mask_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mss_pkg::S_IDLE |-> mask_reg == '0)
        else $error("due mask not empty in idle");

    // Divider remainder must be below a nonzero divisor
    a_rem_below_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mss_pkg::S_BASE && op_period_reg != '0)
            |-> rem_reg < op_period_reg)
        else $error("remainder not below period");

    // A due file check stores the tick time
    a_file_time_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mss_pkg::S_CMP && due && idx_reg == '0)
            |=> last_file_reg == $past(now_reg))
        else $error("file time not updated");

    // File results always carry channel zero
    a_file_chan_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == mss_pkg::KIND_FILE) |-> m_chan_reg == '0)
        else $error("file result with nonzero channel");

endmodule

FILE: dv/multichannel_sample_scheduler_core_test.sv
// Self-checking bench for multichannel_sample_scheduler_core: drives ticks and register writes,
// predicts the file and sample requests per tick and checks every result item in order.
// Depends on mss_pkg and the scheduler core.
module multichannel_sample_scheduler_core_test;

    localparam int NUM_CH          = 22;
    localparam int NUM_CLASSES     = 5;
    // Indexes past the register map; writes to them must be dropped
    localparam logic [mss_pkg::CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [mss_pkg::CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
    // Margin for a tick in progress to finish before touching registers
    localparam int SETTLE_CYCLES   = 1000;
    localparam int PRESSURE_CYCLES = 3000;
    localparam int RANDOM_PHASES   = 5;
    localparam int TICKS_PER_PHASE = 26;
    // Time limit for the whole run of 149 ticks, with up to 23 stalled results each
    localparam longint LIMIT_TIME  = 64'd6_000_000;

    typedef struct packed {
        logic        kind;
        logic [4:0]  channel;
        logic [31:0] stamp;
        logic        last;
    } sched_result_t;

    // Scoreboard: holds its own copy of the periods and stored times and
    // queues the results each tick should produce.
    class sample_schedule_board;
        logic [15:0]   class_period [NUM_CLASSES];
        logic [31:0]   file_period;
        logic [31:0]   chan_time [NUM_CH];
        logic [31:0]   last_file;
        sched_result_t pending_requests [$];
        int            mismatches;
        int            checked;

        function new();
            class_period[mss_pkg::CLS_BATTERY]    = mss_pkg::RST_PERIOD_BATTERY;
            class_period[mss_pkg::CLS_ATMOSPHERE] = mss_pkg::RST_PERIOD_ATMOSPHERE;
            class_period[mss_pkg::CLS_IMU]        = mss_pkg::RST_PERIOD_IMU;
            class_period[mss_pkg::CLS_GPS]        = mss_pkg::RST_PERIOD_GPS;
            class_period[mss_pkg::CLS_VOC]        = mss_pkg::RST_PERIOD_VOC;
            file_period = mss_pkg::RST_FILE_PERIOD;
            foreach (chan_time[i]) chan_time[i] = '0;
            last_file  = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function mss_pkg::cls_t channel_class(int ch);
            if (ch == 0)        return mss_pkg::CLS_BATTERY;
            else if (ch <= 5)   return mss_pkg::CLS_ATMOSPHERE;
            else if (ch <= 14)  return mss_pkg::CLS_IMU;
            else if (ch <= 19)  return mss_pkg::CLS_GPS;
            return mss_pkg::CLS_VOC;
        endfunction

        // Drift-corrected test: round the stored time down to the period grid
        function bit period_elapsed(logic [31:0] now, logic [31:0] stored, logic [31:0] period);
            logic [31:0] base;
            logic [31:0] diff;
            base = (period != 0) ? stored - (stored % period) : stored;
            diff = now - base;
            return diff > period;
        endfunction

        function void write_register(logic [2:0] addr, logic [31:0] data);
            if (addr <= mss_pkg::REG_PERIOD_VOC)
                class_period[addr] = data[15:0];
            else if (addr == mss_pkg::REG_FILE_PERIOD)
                file_period = data;
        endfunction

        function void note_tick(logic [31:0] now);
            sched_result_t tick_results [$];
            sched_result_t req;
            if (period_elapsed(now, last_file, file_period)) begin
                last_file = now;
                req = '{kind: mss_pkg::KIND_FILE, channel: 5'd0, stamp: now, last: 1'b0};
                tick_results.push_back(req);
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if (period_elapsed(now, chan_time[ch], {16'd0, class_period[channel_class(ch)]}))
                begin
                    chan_time[ch] = now;
                    req = '{kind: mss_pkg::KIND_SAMPLE, channel: 5'(ch), stamp: now, last: 1'b0};
                    tick_results.push_back(req);
                end
            end
            if (tick_results.size() > 0) tick_results[tick_results.size()-1].last = 1'b1;
            foreach (tick_results[i]) pending_requests.push_back(tick_results[i]);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_result(logic kind, logic [39:0] data, logic last);
            sched_result_t want;
            checked++;
            if (pending_requests.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d channel %0d stamp %h",
                                          kind, data[4:0], data[36:5]));
                return;
            end
            want = pending_requests.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
            if (data[4:0] !== want.channel)
                report_mismatch($sformatf("channel %0d, want %0d", data[4:0], want.channel));
            if (data[36:5] !== want.stamp)
                report_mismatch($sformatf("stamp %h, want %h", data[36:5], want.stamp));
            if (data[39:37] !== 3'd0)
                report_mismatch($sformatf("padding bits %b not zero", data[39:37]));
            if (last !== want.last)
                report_mismatch($sformatf("tlast %0d, want %0d (channel %0d)",
                                          last, want.last, want.channel));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    sample_schedule_board board = new();

    int ticks_accepted  = 0;
    int results_seen    = 0;
    int settings_used   = 1;
    bit sender_calm     = 1'b0;
    bit pressure_armed  = 1'b0;
    bit pressure_hold   = 1'b0;

    multichannel_sample_scheduler_core #(.NUM_CHANNELS(NUM_CH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Sample both handshakes at the rising edge; predict a tick when it is
    // accepted, before any of its results can appear.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            board.note_tick(s_tdata);
            ticks_accepted++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tuser, m_tdata, m_tlast);
            results_seen++;
        end
    end

    // Mostly no gap, often a short one, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stalls with calm stretches; the pressure flag overrides.
    initial begin
        int hold;
        int calm_left;
        hold = 0;
        calm_left = 0;
        forever begin
            @(negedge aclk);
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 299) == 0)
                calm_left = $urandom_range(100, 600);
            if (hold > 0)
                hold--;
            else if (calm_left == 0)
                hold = pick_gap();
            m_tready = !pressure_hold && (hold == 0);
        end
    end

    // Once armed, wait for a tick to be held at the input while the block is
    // busy, then close the output for a long stretch so everything backs up.
    initial begin
        wait (pressure_armed);
        @(posedge aclk);
        while (!(s_tvalid && !s_tready)) @(posedge aclk);
        pressure_hold = 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge aclk);
        pressure_hold = 1'b0;
    end

    // Offer one tick and hold it until accepted, then idle for a random gap unless the sender is calm
    task automatic send_tick(logic [31:0] now);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = now;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = $urandom();
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Leave the register bus high; the caller lowers it after the last write
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(posedge aclk);
        board.write_register(addr, data);
    endtask

    task automatic release_reg_bus();
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        cfg_wdata = $urandom();
        settings_used++;
    endtask

    // Drop the input, let every expected result drain, then let a tick that
    // gave nothing finish its scan before the registers move.
    task automatic drain_phase();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (board.pending_requests.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function logic [15:0] pick_class_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 16'd0;
        if (r < 16) return 16'd1;
        if (r < 22) return 16'hFFFF;
        return 16'($urandom_range(2, 60));
    endfunction

    function logic [31:0] pick_file_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 32'd0;
        if (r < 16) return 32'd1;
        if (r < 22) return 32'hFFFF_FFFF;
        return 32'($urandom_range(30, 500));
    endfunction

    // New random setting; junk in the upper half of a class period must be dropped
    task automatic randomise_registers();
        logic [31:0] junk;
        for (int idx = mss_pkg::REG_PERIOD_BATTERY; idx <= mss_pkg::REG_PERIOD_VOC; idx++) begin
            junk = $urandom() & 32'hFFFF_0000;
            write_reg(3'(idx), junk | {16'd0, pick_class_period()});
        end
        write_reg(mss_pkg::REG_FILE_PERIOD, pick_file_period());
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
        release_reg_bus();
    endtask

    // Mostly a clock that moves forward in steps, some crawling across
    // period edges, a few wild jumps
    task automatic run_random_ticks(int count, bit near_wrap);
        logic [31:0] now;
        int          step_max;
        int          r;
        step_max = $urandom_range(8, 120);
        now = near_wrap ? 32'hFFFF_FFFF - 32'($urandom_range(0, 2000)) : $urandom();
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                now = now + 32'($urandom_range(0, step_max));
            else if (r < 92)
                now = now + 32'($urandom_range(0, 2));
            else
                now = $urandom();
            send_tick(now);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset periods: nothing due at zero, IMU just not due at 100 but due
        // at 101, everything due at the top of the range, then wrap to zero.
        send_tick(32'd0);
        send_tick(32'd100);
        send_tick(32'd101);
        send_tick(32'd501);
        send_tick(32'd1001);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd0);
        send_tick(32'd60_001);
        drain_phase();

        // Writes past the map are ignored, upper bits of a class period are
        // dropped, and zero periods skip the rounding.
        write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_LO, 32'h0000_0000);
        write_reg(mss_pkg::REG_PERIOD_BATTERY, 32'hFFFF_0001);
        write_reg(mss_pkg::REG_PERIOD_ATMOSPHERE, 32'h5A5A_0007);
        write_reg(mss_pkg::REG_PERIOD_IMU, 32'h0000_0000);
        write_reg(mss_pkg::REG_PERIOD_GPS, 32'h0000_FFFF);
        write_reg(mss_pkg::REG_PERIOD_VOC, 32'hA5A5_0001);
        write_reg(mss_pkg::REG_FILE_PERIOD, 32'd0);
        release_reg_bus();
        send_tick(32'd5);
        send_tick(32'd5);
        send_tick(32'd6);
        send_tick(32'd70_000);
        send_tick(32'd135_535);
        send_tick(32'hFFFF_FFFF);
        drain_phase();

        // Widest periods everywhere
        for (int idx = mss_pkg::REG_PERIOD_BATTERY; idx <= mss_pkg::REG_PERIOD_VOC; idx++)
            write_reg(3'(idx), 32'h0000_FFFF);
        write_reg(mss_pkg::REG_FILE_PERIOD, 32'hFFFF_FFFF);
        release_reg_bus();
        send_tick(32'd0);
        send_tick(32'd65_535);
        send_tick(32'd65_536);
        send_tick(32'h8000_0000);
        send_tick(32'hFFFF_FFFF);
        drain_phase();

        // Random settings, one of them with the long output hold
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            randomise_registers();
            sender_calm = ($urandom_range(0, 3) == 0);
            if (p == 1) pressure_armed = 1'b1;
            run_random_ticks(TICKS_PER_PHASE, p[0]);
            drain_phase();
        end

        $display("Run covered %0d ticks and %0d result items across %0d register settings,",
                 ticks_accepted, results_seen, settings_used);
        $display("including zero, unit and widest periods and one long output hold-off.");
        if (board.mismatches == 0 && board.pending_requests.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(LIMIT_TIME);
        $display("Timed out with %0d results still expected", board.pending_requests.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
